// ----- rtl/core/hash_group_row_matcher_defines.svh -----
// assertion helpers for the row matcher
`ifndef HASH_GROUP_ROW_MATCHER_DEFINES_SVH
`define HASH_GROUP_ROW_MATCHER_DEFINES_SVH

// clocked property, disabled in reset
`define HGRM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hgrm assertion failed");

// same with a message of its own
`define HGRM_ASSERT_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- rtl/core/hgrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hgrm_pkg;

   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_NUM_BUCKETS = 1024;

   localparam logic [3:0]  KEY_BYTES = 4'd8;
   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

   localparam logic [1:0] OP_FIND  = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] CSR_DEFAULT_MATCH_BYTES = 2'd0;
   localparam logic [1:0] CSR_BUCKET_MASK         = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_HASH,
      ST_BKT_RD,
      ST_BKT_CHK,
      ST_ROW_RD,
      ST_ROW_CHK,
      ST_INSERT
   } state_type;

   typedef struct packed {
      logic       init;
      logic       step;
      logic [7:0] data;
   } crc_ctl_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc_cur,
                                            input logic [7:0]  data);
      logic [31:0] c;
      c = crc_cur ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hgrm_crc.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hgrm_crc (
   input  wire                  clock,
   input  wire hgrm_pkg::crc_ctl_type ctl,
   output logic [31:0]          crc
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = hgrm_pkg::CRC_INIT;
      end else if (ctl.step) begin
         crc_in = hgrm_pkg::crc_byte(crc_ff, ctl.data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   // final xor applied on the way out
   assign crc = crc_ff ^ hgrm_pkg::CRC_INIT;

endmodule

`default_nettype wire

// ----- rtl/core/hgrm_bkt_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hgrm_bkt_mem #(
   parameter int NUM_BUCKETS = hgrm_pkg::DEF_NUM_BUCKETS,
   parameter int MAX_ROWS    = hgrm_pkg::DEF_MAX_ROWS,
   localparam int BW = $clog2(NUM_BUCKETS),
   localparam int RW = $clog2(MAX_ROWS)
) (
   input  wire           clock,
   input  wire  [BW-1:0] rd_addr,
   output logic          rd_used,
   output logic [RW-1:0] rd_head,
   input  wire           wr_en,
   input  wire  [BW-1:0] wr_addr,
   input  wire           wr_used,
   input  wire  [RW-1:0] wr_head
);

   logic [RW:0] mem [NUM_BUCKETS];
   logic [RW:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_used, wr_head};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_used = rd_ff[RW];
   assign rd_head = rd_ff[RW-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/hgrm_row_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hgrm_row_mem #(
   parameter int MAX_ROWS = hgrm_pkg::DEF_MAX_ROWS,
   localparam int RW = $clog2(MAX_ROWS)
) (
   input  wire           clock,
   input  wire  [RW-1:0] rd_addr,
   output logic [63:0]   rd_key,
   output logic [RW-1:0] rd_link,
   input  wire  [RW-1:0] wr_addr,
   input  wire           key_we,
   input  wire  [63:0]   key_wd,
   input  wire           link_we,
   input  wire  [RW-1:0] link_wd
);

   logic [63:0]   key_mem  [MAX_ROWS];
   logic [RW-1:0] link_mem [MAX_ROWS];
   logic [63:0]   key_ff;
   logic [RW-1:0] link_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_wd;
      end
      if (link_we) begin
         link_mem[wr_addr] <= link_wd;
      end
      key_ff  <= key_mem[rd_addr];
      link_ff <= link_mem[rd_addr];
   end

   assign rd_key  = key_ff;
   assign rd_link = link_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hash_group_row_matcher.sv -----
// steps: hash the compared bytes, read and check the bucket, read and check each chain row walked,
//    insert on an add, then register the response
// throughput: one request at a time, busy stays high until the response strobe
// clear sweeps every bucket entry, one bucket entry per cycle through the bucket memory
// reset: synchronous; after reset the same sweep runs with busy high
// the response is a one-cycle strobe and cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

module hash_group_row_matcher #(
   parameter int MAX_ROWS    = hgrm_pkg::DEF_MAX_ROWS,
   parameter int NUM_BUCKETS = hgrm_pkg::DEF_NUM_BUCKETS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_operation,
   input  wire  [63:0] req_key,
   input  wire  [3:0]  req_width_override,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic        rsp_row_valid,
   output logic [9:0]  rsp_row_index,
   output logic        rsp_table_full,
   input  wire         csr_write_enable,
   input  wire  [1:0]  csr_index,
   input  wire  [9:0]  csr_write_data
);

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_ROWS + 1);

   hgrm_pkg::state_type state_ff, state_in;
   logic          add_ff, add_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic [63:0]   key_ff, key_in;
   logic [3:0]    wid_ff, wid_in;
   logic [2:0]    idx_ff, idx_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] count_ff, count_in;
   logic [BW-1:0] ctr_ff, ctr_in;
   logic [3:0]    dmb_ff;
   logic [9:0]    mask_ff;
   logic          rv_ff, rv_in;
   logic          found_ff, found_in;
   logic          rvalid_ff, rvalid_in;
   logic [RW-1:0] rrow_ff, rrow_in;
   logic          full_ff, full_in;

   hgrm_pkg::crc_ctl_type crc_ctl;
   logic [31:0]   crc;
   logic [BW+9:0] bkt_wide;
   logic [BW-1:0] bucket;
   logic [63:0]   kmask;
   logic [3:0]    wsel;
   logic          tbl_full;
   logic          key_hit;
   logic [RW+9:0] rrow_wide;

   logic          b_used;
   logic [RW-1:0] b_head;
   logic          b_we;
   logic [BW-1:0] b_waddr;
   logic          b_wused;
   logic [RW-1:0] r_raddr;
   logic [63:0]   r_key;
   logic [RW-1:0] r_link;
   logic [RW-1:0] r_waddr;
   logic          r_kwe;
   logic          r_lwe;
   logic [RW-1:0] r_lwd;

   hgrm_crc u_crc (
      .clock (clock),
      .ctl   (crc_ctl),
      .crc   (crc)
   );

   hgrm_bkt_mem #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_ROWS(MAX_ROWS)) u_bkt (
      .clock   (clock),
      .rd_addr (bucket),
      .rd_used (b_used),
      .rd_head (b_head),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_used (b_wused),
      .wr_head (count_ff[RW-1:0])
   );

   hgrm_row_mem #(.MAX_ROWS(MAX_ROWS)) u_row (
      .clock   (clock),
      .rd_addr (r_raddr),
      .rd_key  (r_key),
      .rd_link (r_link),
      .wr_addr (r_waddr),
      .key_we  (r_kwe),
      .key_wd  (key_ff & kmask),
      .link_we (r_lwe),
      .link_wd (r_lwd)
   );

   assign bkt_wide = {BW'(0), crc[9:0] & mask_ff};
   assign bucket   = bkt_wide[BW-1:0];
   assign tbl_full = (count_ff == CW'(MAX_ROWS));
   assign key_hit  = (((r_key ^ key_ff) & kmask) == 64'd0);
   assign r_raddr  = row_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         kmask[8*i +: 8] = (4'(i) < wid_ff) ? 8'hFF : 8'h00;
      end
   end

   // effective compare width
   always_comb begin
      wsel = (req_width_override == 4'd0) ? dmb_ff : req_width_override;
      if (wsel == 4'd0) begin
         wsel = 4'd1;
      end
      if (wsel > hgrm_pkg::KEY_BYTES) begin
         wsel = hgrm_pkg::KEY_BYTES;
      end
   end

   always_comb begin
      state_in   = state_ff;
      add_in     = add_ff;
      clr_rsp_in = clr_rsp_ff;
      key_in     = key_ff;
      wid_in     = wid_ff;
      idx_in     = idx_ff;
      row_in     = row_ff;
      count_in   = count_ff;
      ctr_in     = ctr_ff;
      rv_in      = 1'b0;
      found_in   = found_ff;
      rvalid_in  = rvalid_ff;
      rrow_in    = rrow_ff;
      full_in    = full_ff;
      crc_ctl    = '{init: 1'b0, step: 1'b0, data: key_ff[{idx_ff, 3'd0} +: 8]};
      b_we       = 1'b0;
      b_waddr    = bucket;
      b_wused    = 1'b1;
      r_waddr    = row_ff;
      r_kwe      = 1'b0;
      r_lwe      = 1'b0;
      r_lwd      = count_ff[RW-1:0];

      case (state_ff)
         hgrm_pkg::ST_IDLE: begin
            if (start) begin
               key_in       = req_key;
               wid_in       = wsel;
               idx_in       = 3'd0;
               add_in       = (req_operation == hgrm_pkg::OP_ADD);
               crc_ctl.init = 1'b1;
               if (req_operation == hgrm_pkg::OP_CLEAR) begin
                  count_in   = '0;
                  ctr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = hgrm_pkg::ST_CLEAR;
               end else begin
                  state_in = hgrm_pkg::ST_HASH;
               end
            end
         end
         hgrm_pkg::ST_CLEAR: begin
            b_we    = 1'b1;
            b_waddr = ctr_ff;
            b_wused = 1'b0;
            ctr_in  = ctr_ff + 1'b1;
            if (ctr_ff == BW'(NUM_BUCKETS - 1)) begin
               state_in = hgrm_pkg::ST_IDLE;
               if (clr_rsp_ff) begin
                  rv_in     = 1'b1;
                  found_in  = 1'b0;
                  rvalid_in = 1'b0;
                  rrow_in   = '0;
                  full_in   = 1'b0;
               end
               clr_rsp_in = 1'b0;
            end
         end
         hgrm_pkg::ST_HASH: begin
            crc_ctl.step = 1'b1;
            idx_in       = idx_ff + 1'b1;
            if ({1'b0, idx_ff} == wid_ff - 4'd1) begin
               state_in = hgrm_pkg::ST_BKT_RD;
            end
         end
         hgrm_pkg::ST_BKT_RD: begin
            state_in = hgrm_pkg::ST_BKT_CHK;
         end
         hgrm_pkg::ST_BKT_CHK: begin
            if (b_used) begin
               row_in   = b_head;
               state_in = hgrm_pkg::ST_ROW_RD;
            end else if (!add_ff || tbl_full) begin
               rv_in     = 1'b1;
               found_in  = 1'b0;
               rvalid_in = 1'b0;
               rrow_in   = '0;
               full_in   = add_ff;
               state_in  = hgrm_pkg::ST_IDLE;
            end else begin
               b_we     = 1'b1;
               state_in = hgrm_pkg::ST_INSERT;
            end
         end
         hgrm_pkg::ST_ROW_RD: begin
            state_in = hgrm_pkg::ST_ROW_CHK;
            // chain end past the stored rows counts as a miss
            if (CW'(row_ff) >= count_ff) begin
               if (!add_ff || tbl_full) begin
                  rv_in     = 1'b1;
                  found_in  = 1'b0;
                  rvalid_in = 1'b0;
                  rrow_in   = '0;
                  full_in   = add_ff;
                  state_in  = hgrm_pkg::ST_IDLE;
               end else begin
                  r_lwe    = 1'b1;
                  state_in = hgrm_pkg::ST_INSERT;
               end
            end
         end
         hgrm_pkg::ST_ROW_CHK: begin
            if (key_hit) begin
               rv_in     = 1'b1;
               found_in  = 1'b1;
               rvalid_in = 1'b1;
               rrow_in   = row_ff;
               full_in   = 1'b0;
               state_in  = hgrm_pkg::ST_IDLE;
            end else if (r_link != '0 && r_link > row_ff) begin
               row_in   = r_link;
               state_in = hgrm_pkg::ST_ROW_RD;
            end else if (!add_ff || tbl_full) begin
               rv_in     = 1'b1;
               found_in  = 1'b0;
               rvalid_in = 1'b0;
               rrow_in   = '0;
               full_in   = add_ff;
               state_in  = hgrm_pkg::ST_IDLE;
            end else begin
               r_lwe    = 1'b1;
               state_in = hgrm_pkg::ST_INSERT;
            end
         end
         hgrm_pkg::ST_INSERT: begin
            r_waddr   = count_ff[RW-1:0];
            r_kwe     = 1'b1;
            r_lwe     = 1'b1;
            r_lwd     = '0;
            count_in  = count_ff + 1'b1;
            rv_in     = 1'b1;
            found_in  = 1'b0;
            rvalid_in = 1'b1;
            rrow_in   = count_ff[RW-1:0];
            full_in   = 1'b0;
            state_in  = hgrm_pkg::ST_IDLE;
         end
         default: begin
            state_in = hgrm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hgrm_pkg::ST_CLEAR;
         clr_rsp_ff <= 1'b0;
         ctr_ff     <= '0;
         count_ff   <= '0;
         rv_ff      <= 1'b0;
         dmb_ff     <= 4'd8;
         mask_ff    <= 10'd1023;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
         ctr_ff     <= ctr_in;
         count_ff   <= count_in;
         rv_ff      <= rv_in;
         if (csr_write_enable) begin
            case (csr_index)
               hgrm_pkg::CSR_DEFAULT_MATCH_BYTES: dmb_ff  <= csr_write_data[3:0];
               hgrm_pkg::CSR_BUCKET_MASK:         mask_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      add_ff    <= add_in;
      key_ff    <= key_in;
      wid_ff    <= wid_in;
      idx_ff    <= idx_in;
      row_ff    <= row_in;
      found_ff  <= found_in;
      rvalid_ff <= rvalid_in;
      rrow_ff   <= rrow_in;
      full_ff   <= full_in;
   end

   assign rrow_wide      = {10'd0, rrow_ff};
   assign busy           = (state_ff != hgrm_pkg::ST_IDLE);
   assign rsp_valid      = rv_ff;
   assign rsp_found      = found_ff;
   assign rsp_row_valid  = rvalid_ff;
   assign rsp_row_index  = rrow_wide[9:0];
   assign rsp_table_full = full_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hgrm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "hash_group_row_matcher_defines.svh"

module hgrm_checker (
   input wire       clock,
   input wire       reset,
   input wire       start,
   input wire       busy,
   input wire       rsp_valid,
   input wire       rsp_found,
   input wire       rsp_row_valid,
   input wire [9:0] rsp_row_index,
   input wire       rsp_table_full
);

   `HGRM_ASSERT(a_rsp_when_idle, clock, reset, rsp_valid |-> !busy)
   `HGRM_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy)
   `HGRM_ASSERT_MSG(a_full_no_row, clock, reset, (rsp_valid && rsp_table_full) |-> (!rsp_row_valid && !rsp_found), "full response carries a row")
   `HGRM_ASSERT_MSG(a_null_zero, clock, reset, (rsp_valid && !rsp_row_valid) |-> (rsp_row_index == 10'd0 && !rsp_found), "null response not zero")
   `HGRM_ASSERT(a_found_valid, clock, reset, (rsp_valid && rsp_found) |-> rsp_row_valid)

endmodule

bind hash_group_row_matcher hgrm_checker u_hgrm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_found      (rsp_found),
   .rsp_row_valid  (rsp_row_valid),
   .rsp_row_index  (rsp_row_index),
   .rsp_table_full (rsp_table_full)
);

`default_nettype wire
